// ===== rtl/ble_link_credit_tracker_core_assert.svh =====
`ifndef BLE_LINK_CREDIT_TRACKER_CORE_ASSERT_SVH
`define BLE_LINK_CREDIT_TRACKER_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BLCT_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// next-cycle implication, checked outside reset
`define BLCT_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

// ===== rtl/blct_pkg.sv =====
package blct_pkg;

   localparam int TIME_W     = 64;
   localparam int INTERVAL_W = 32;
   localparam int OP_W       = 3;
   localparam int ARG_W      = 16;
   localparam int MTU_W      = 10;
   localparam int CNT8_W     = 8;
   localparam int TOTAL_W    = 32;
   localparam int STATUS_W   = 3;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 32;

   // request beat layout
   localparam int REQ_NOW_LO  = 0;
   localparam int REQ_MTU_LO  = REQ_NOW_LO + TIME_W;
   localparam int REQ_FLAG_LO = REQ_MTU_LO + ARG_W;
   localparam int REQ_LEN_LO  = REQ_FLAG_LO + 1;
   localparam int REQ_BITS    = REQ_LEN_LO + ARG_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;

   localparam int RSP_BITS    = STATUS_W + 3 * CNT8_W + 1 + MTU_W + 4 * TOTAL_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_W   = RSP_TDATA_W - RSP_BITS;

   localparam int unsigned DEF_MIN_MTU             = 23;
   localparam int unsigned DEF_MAX_MTU             = 247;
   localparam int unsigned DEF_VALUE_OVERHEAD      = 3;
   localparam int unsigned DEF_SMALL_MTU_VALUE_MAX = 20;

   localparam logic [INTERVAL_W-1:0] RST_EVENT_INTERVAL = 32'd7500;
   localparam logic [CNT8_W-1:0]     RST_CREDIT_LIMIT   = 8'd4;

   localparam logic [CSR_ADDR_W-1:0] CSR_EVENT_INTERVAL = 1'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CREDIT_LIMIT   = 1'd1;

   localparam logic [OP_W-1:0] OP_CONNECT    = 3'd0;
   localparam logic [OP_W-1:0] OP_DISCONNECT = 3'd1;
   localparam logic [OP_W-1:0] OP_SET_MTU    = 3'd2;
   localparam logic [OP_W-1:0] OP_SET_STALL  = 3'd3;
   localparam logic [OP_W-1:0] OP_NOTIFY     = 3'd4;
   localparam logic [OP_W-1:0] OP_CONN_EVENT = 3'd5;

   localparam logic [STATUS_W-1:0] ST_OK         = 3'd0;
   localparam logic [STATUS_W-1:0] ST_BAD_ARG    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOT_CONN   = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOTIFY_OFF = 3'd3;
   localparam logic [STATUS_W-1:0] ST_TOO_LONG   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_NO_CREDIT  = 3'd5;
   localparam logic [STATUS_W-1:0] ST_EARLY      = 3'd6;

   typedef struct packed {
      logic capture;
      logic div_start;
      logic commit;
   } blct_cmd_type;

   typedef struct packed {
      logic need_div;
      logic div_done;
   } blct_sts_type;

endpackage

// ===== rtl/blct_div.sv =====
module blct_div import blct_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [TIME_W-1:0]     dividend,
   input  logic [INTERVAL_W-1:0] divisor,
   output logic                  done,
   output logic [INTERVAL_W-1:0] remainder
);

   localparam int STEPS = TIME_W;
   localparam int CNT_W = $clog2(STEPS);

   logic                  busy_ff;
   logic                  done_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [TIME_W-1:0]     shf_ff;
   logic [INTERVAL_W-1:0] rem_ff;
   logic [INTERVAL_W-1:0] dvs_ff;

   logic                  last;
   logic [INTERVAL_W:0]   cand;
   logic [INTERVAL_W:0]   diff;
   logic [INTERVAL_W-1:0] rem_in;

   // one restoring step per cycle, dividend bits enter msb first
   always_comb begin
      last   = (cnt_ff == CNT_W'(STEPS - 1));
      cand   = {rem_ff, shf_ff[TIME_W-1]};
      diff   = cand - {1'b0, dvs_ff};
      rem_in = (cand >= {1'b0, dvs_ff}) ? diff[INTERVAL_W-1:0] : cand[INTERVAL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && last;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
            if (last) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         shf_ff <= dividend;
         rem_ff <= '0;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         shf_ff <= {shf_ff[TIME_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/blct_ctrl.sv =====
module blct_ctrl import blct_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  blct_sts_type sts,
   output blct_cmd_type cmd
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_EXEC   = 2'd1;
   localparam logic [1:0] S_DIV    = 2'd2;
   localparam logic [1:0] S_COMMIT = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       slot_free;

   always_comb begin
      slot_free     = !rsp_valid_ff || rsp_tready;
      req_tready    = (state_ff == S_IDLE);
      cmd.capture   = req_tvalid && (state_ff == S_IDLE);
      cmd.div_start = (state_ff == S_EXEC) && sts.need_div;
      cmd.commit    = (state_ff == S_COMMIT) && slot_free;
      state_in      = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in = sts.need_div ? S_DIV : S_COMMIT;
         end
         S_DIV: begin
            if (sts.div_done) begin
               state_in = S_COMMIT;
            end
         end
         S_COMMIT: begin
            if (slot_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // result register holds until taken, reloads on commit
      rsp_valid_in = cmd.commit ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

// ===== rtl/blct_dpath.sv =====
module blct_dpath import blct_pkg::*; #(
   parameter int unsigned MIN_MTU             = DEF_MIN_MTU,
   parameter int unsigned MAX_MTU             = DEF_MAX_MTU,
   parameter int unsigned VALUE_OVERHEAD      = DEF_VALUE_OVERHEAD,
   parameter int unsigned SMALL_MTU_VALUE_MAX = DEF_SMALL_MTU_VALUE_MAX
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [OP_W-1:0]        req_tuser,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  blct_cmd_type           cmd,
   output blct_sts_type           sts
);

   localparam logic [ARG_W-1:0] MIN_A   = ARG_W'(MIN_MTU);
   localparam logic [ARG_W-1:0] MAX_A   = ARG_W'(MAX_MTU);
   localparam logic [MTU_W-1:0] MIN_M   = MTU_W'(MIN_MTU);
   localparam logic [MTU_W-1:0] MAX_M   = MTU_W'(MAX_MTU);
   localparam logic [ARG_W-1:0] OVH_A   = ARG_W'(VALUE_OVERHEAD);
   localparam logic [ARG_W-1:0] SMALL_A = ARG_W'(SMALL_MTU_VALUE_MAX);

   // configuration
   logic [INTERVAL_W-1:0] interval_ff;
   logic [CNT8_W-1:0]     limit_ff;

   // captured request
   logic [OP_W-1:0]   op_ff;
   logic [TIME_W-1:0] now_ff;
   logic [ARG_W-1:0]  mtu_arg_ff;
   logic              flag_ff;
   logic [ARG_W-1:0]  len_ff;

   // link state
   logic                 connected_ff, connected_in;
   logic                 notify_ff, notify_in;
   logic                 stalled_ff, stalled_in;
   logic [MTU_W-1:0]     link_mtu_ff, link_mtu_in;
   logic [CNT8_W-1:0]    credits_ff, credits_in;
   logic [CNT8_W-1:0]    pending_ff, pending_in;
   logic [TIME_W-1:0]    next_time_ff, next_time_in;
   logic [TOTAL_W-1:0]   gen_ff, gen_in;
   logic [TOTAL_W-1:0]   submitted_ff, submitted_in;
   logic [TOTAL_W-1:0]   completed_ff, completed_in;
   logic [TOTAL_W-1:0]   dropped_ff, dropped_in;

   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   logic [STATUS_W-1:0]   status;
   logic [CNT8_W-1:0]     count;
   logic                  early;
   logic [TIME_W-1:0]     elapsed;
   logic [INTERVAL_W-1:0] rem;
   logic                  div_done;
   logic [ARG_W-1:0]      mtu_lo;
   logic [ARG_W-1:0]      mtu_clamp;
   logic [MTU_W-1:0]      mtu_cap;
   logic [ARG_W-1:0]      pay_limit;
   logic [TOTAL_W-1:0]    gen_inc;

   blct_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (elapsed),
      .divisor   (interval_ff),
      .done      (div_done),
      .remainder (rem)
   );

   always_comb begin
      early        = now_ff < next_time_ff;
      elapsed      = now_ff - next_time_ff;
      sts.need_div = (op_ff == OP_CONN_EVENT) && connected_ff && !early
                     && (interval_ff != '0);
      sts.div_done = div_done;

      mtu_lo    = (mtu_arg_ff < MIN_A) ? MIN_A : mtu_arg_ff;
      mtu_clamp = (mtu_lo > MAX_A) ? MAX_A : mtu_lo;
      mtu_cap   = (link_mtu_ff > MAX_M) ? MAX_M : link_mtu_ff;
      pay_limit = (link_mtu_ff < MIN_M) ? SMALL_A : (ARG_W'(mtu_cap) - OVH_A);
      gen_inc   = gen_ff + TOTAL_W'(1);
   end

   always_comb begin
      status       = ST_OK;
      count        = '0;
      connected_in = connected_ff;
      notify_in    = notify_ff;
      stalled_in   = stalled_ff;
      link_mtu_in  = link_mtu_ff;
      credits_in   = credits_ff;
      pending_in   = pending_ff;
      next_time_in = next_time_ff;
      gen_in       = gen_ff;
      submitted_in = submitted_ff;
      completed_in = completed_ff;
      dropped_in   = dropped_ff;
      case (op_ff)
         OP_CONNECT: begin
            if (interval_ff == '0 || limit_ff == '0) begin
               status = ST_BAD_ARG;
            end else begin
               // generation skips zero on wrap
               gen_in       = (gen_inc == '0) ? TOTAL_W'(1) : gen_inc;
               link_mtu_in  = mtu_clamp[MTU_W-1:0];
               credits_in   = limit_ff;
               pending_in   = '0;
               connected_in = 1'b1;
               notify_in    = flag_ff;
               stalled_in   = 1'b0;
               next_time_in = now_ff + TIME_W'(interval_ff);
            end
         end
         OP_DISCONNECT: begin
            count        = pending_ff;
            dropped_in   = dropped_ff + TOTAL_W'(pending_ff);
            credits_in   = '0;
            pending_in   = '0;
            connected_in = 1'b0;
            notify_in    = 1'b0;
            stalled_in   = 1'b0;
            next_time_in = '0;
         end
         OP_SET_MTU: begin
            if (mtu_arg_ff < MIN_A || mtu_arg_ff > MAX_A) begin
               status = ST_BAD_ARG;
            end else if (!connected_ff) begin
               status = ST_NOT_CONN;
            end else begin
               link_mtu_in = mtu_arg_ff[MTU_W-1:0];
            end
         end
         OP_SET_STALL: begin
            stalled_in = flag_ff;
         end
         OP_NOTIFY: begin
            if (len_ff == '0) begin
               status = ST_BAD_ARG;
            end else if (!connected_ff) begin
               status = ST_NOT_CONN;
            end else if (!notify_ff) begin
               status = ST_NOTIFY_OFF;
            end else if (len_ff > pay_limit) begin
               status = ST_TOO_LONG;
            end else if (credits_ff == '0 || pending_ff >= limit_ff) begin
               status = ST_NO_CREDIT;
            end else begin
               credits_in   = credits_ff - CNT8_W'(1);
               pending_in   = pending_ff + CNT8_W'(1);
               submitted_in = submitted_ff + TOTAL_W'(1);
            end
         end
         OP_CONN_EVENT: begin
            if (!connected_ff) begin
               status = ST_NOT_CONN;
            end else if (early) begin
               status = ST_EARLY;
            end else begin
               // next + (q+1)*interval == now - rem + interval
               if (interval_ff != '0) begin
                  next_time_in = now_ff - TIME_W'(rem) + TIME_W'(interval_ff);
               end
               if (!stalled_ff) begin
                  count        = pending_ff;
                  pending_in   = '0;
                  credits_in   = limit_ff;
                  completed_in = completed_ff + TOTAL_W'(pending_ff);
               end
            end
         end
         default: begin
            status = ST_BAD_ARG;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= RST_EVENT_INTERVAL;
         limit_ff    <= RST_CREDIT_LIMIT;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_EVENT_INTERVAL: interval_ff <= csr_wdata[INTERVAL_W-1:0];
            CSR_CREDIT_LIMIT:   limit_ff    <= csr_wdata[CNT8_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_tuser;
         now_ff     <= req_tdata[REQ_NOW_LO +: TIME_W];
         mtu_arg_ff <= req_tdata[REQ_MTU_LO +: ARG_W];
         flag_ff    <= req_tdata[REQ_FLAG_LO];
         len_ff     <= req_tdata[REQ_LEN_LO +: ARG_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         connected_ff <= 1'b0;
         notify_ff    <= 1'b0;
         stalled_ff   <= 1'b0;
         link_mtu_ff  <= '0;
         credits_ff   <= '0;
         pending_ff   <= '0;
         next_time_ff <= '0;
         gen_ff       <= '0;
         submitted_ff <= '0;
         completed_ff <= '0;
         dropped_ff   <= '0;
      end else if (cmd.commit) begin
         connected_ff <= connected_in;
         notify_ff    <= notify_in;
         stalled_ff   <= stalled_in;
         link_mtu_ff  <= link_mtu_in;
         credits_ff   <= credits_in;
         pending_ff   <= pending_in;
         next_time_ff <= next_time_in;
         gen_ff       <= gen_in;
         submitted_ff <= submitted_in;
         completed_ff <= completed_in;
         dropped_ff   <= dropped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_data_ff <= {{RSP_PAD_W{1'b0}}, dropped_in, completed_in, submitted_in, gen_in,
                         link_mtu_in, connected_in, pending_in, credits_in, count, status};
      end
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

// ===== rtl/ble_link_credit_tracker_core.sv =====
// a request beat is captured in S_IDLE, evaluated in S_EXEC and written to the response
//   register in S_COMMIT; a due connection event with a nonzero interval first waits in
//   S_DIV (64-step restoring divider, one bit per cycle); one request at a time
// a new request is taken while the previous response beat still waits
// reset (synchronous, active high) clears the link state and counters and loads
//   event_interval 7500 and credit_limit 4
`include "ble_link_credit_tracker_core_assert.svh"

module ble_link_credit_tracker_core import blct_pkg::*; #(
   parameter int unsigned MIN_MTU             = DEF_MIN_MTU,
   parameter int unsigned MAX_MTU             = DEF_MAX_MTU,
   parameter int unsigned VALUE_OVERHEAD      = DEF_VALUE_OVERHEAD,
   parameter int unsigned SMALL_MTU_VALUE_MAX = DEF_SMALL_MTU_VALUE_MAX
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // now_time[63:0], mtu_value[79:64], flag_value[80], value_length[96:81]
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // opcode[2:0]
   input  logic [OP_W-1:0]        req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // status[2:0], event_count[10:3], credits_now[18:11], pending_now[26:19],
   // link_up[27], mtu_now[37:28], generation_now[69:38], submitted_total[101:70],
   // completed_total[133:102], dropped_total[165:134]
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_ADDR_W-1:0]  csr_addr,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   blct_cmd_type cmd;
   blct_sts_type sts;

   blct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   blct_dpath #(
      .MIN_MTU             (MIN_MTU),
      .MAX_MTU             (MAX_MTU),
      .VALUE_OVERHEAD      (VALUE_OVERHEAD),
      .SMALL_MTU_VALUE_MAX (SMALL_MTU_VALUE_MAX)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .sts       (sts)
   );

   // a commit never overwrites a response beat that is still waiting
   `BLCT_ASSERT_NOW(a_no_overwrite, clock, reset, cmd.commit, !rsp_tvalid || rsp_tready)
   // every commit shows up as a response beat
   `BLCT_ASSERT_NEXT(a_commit_shows, clock, reset, cmd.commit, rsp_tvalid)
   // one item at a time: taking a request never coincides with a commit or a divider start
   `BLCT_ASSERT_NOW(a_one_item, clock, reset, req_tvalid && req_tready, !cmd.commit && !cmd.div_start)

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
   import blct_pkg::*;

   localparam logic [OP_W-1:0] OP_RESERVED_6 = 3'd6;
   localparam logic [OP_W-1:0] OP_RESERVED_7 = 3'd7;
   localparam int NO_PIN         = -1;
   localparam int STALL_PCT      = 7;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 80;
   localparam int PHASE_ITEMS    = 70;
   localparam int NUM_PHASES     = 8;
   localparam int CALM_PHASE     = 5;
   localparam int PLAN_ROWS      = 28;
   localparam int MAX_REPORTS    = 10;

   typedef struct packed {
      logic [RSP_PAD_W-1:0] pad;
      logic [TOTAL_W-1:0]   dropped;
      logic [TOTAL_W-1:0]   completed;
      logic [TOTAL_W-1:0]   submitted;
      logic [TOTAL_W-1:0]   generation;
      logic [MTU_W-1:0]     mtu;
      logic                 link_up;
      logic [CNT8_W-1:0]    pending;
      logic [CNT8_W-1:0]    credits;
      logic [CNT8_W-1:0]    count;
      logic [STATUS_W-1:0]  status;
   } link_report_type;

   typedef struct {
      logic [OP_W-1:0]   op;
      logic [TIME_W-1:0] now;
      logic [ARG_W-1:0]  mtu;
      logic              flag;
      logic [ARG_W-1:0]  len;
      int                pin;
   } plan_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   // now_time, mtu_value, flag_value, value_length
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   // opcode
   logic [OP_W-1:0]        req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // status, event_count, credits_now, pending_now, link_up, mtu_now,
   // generation_now, submitted_total, completed_total, dropped_total
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]  csr_addr = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   // shadow registers and link state of the predictor
   logic [INTERVAL_W-1:0] sh_interval;
   logic [CNT8_W-1:0]     sh_limit;
   logic                  lk_up, lk_notify, lk_stalled;
   logic [MTU_W-1:0]      lk_mtu;
   logic [CNT8_W-1:0]     lk_credits, lk_pending;
   logic [TIME_W-1:0]     lk_due;
   logic [TOTAL_W-1:0]    lk_gen, lk_submitted, lk_completed, lk_dropped;

   link_report_type report_q[$];
   int              pinned_q[$];
   logic            calm = 1'b0;
   int              mismatches = 0;
   int              events_sent = 0;
   int              reports_checked = 0;
   int              ok_reports = 0;
   int              settings_used = 1;
   int              quiet_cycles = 0;

   plan_row_type plan [PLAN_ROWS] = '{
      '{OP_NOTIFY,     64'd0, 16'd0, 1'b0, 16'd0, ST_BAD_ARG},
      '{OP_NOTIFY,     64'd0, 16'd0, 1'b0, 16'd1, ST_NOT_CONN},
      '{OP_CONN_EVENT, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 1'b0, 16'd0, ST_NOT_CONN},
      '{OP_SET_MTU,    64'd0, 16'd100, 1'b0, 16'd0, ST_NOT_CONN},
      '{OP_SET_MTU,    64'd0, 16'd22, 1'b0, 16'd0, ST_BAD_ARG},
      '{OP_SET_MTU,    64'd0, 16'd248, 1'b0, 16'd0, ST_BAD_ARG},
      '{OP_SET_MTU,    64'd0, 16'hFFFF, 1'b1, 16'hFFFF, ST_BAD_ARG},
      '{OP_RESERVED_6, 64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 1'b1, 16'hFFFF, ST_BAD_ARG},
      '{OP_RESERVED_7, 64'd0, 16'd0, 1'b0, 16'd0, ST_BAD_ARG},
      '{OP_SET_STALL,  64'd0, 16'd0, 1'b1, 16'd0, ST_OK},
      '{OP_CONNECT,    64'd0, 16'd0, 1'b0, 16'd0, ST_OK},
      '{OP_NOTIFY,     64'd0, 16'd0, 1'b0, 16'd1, ST_NOTIFY_OFF},
      '{OP_CONNECT,    64'd1000, 16'hFFFF, 1'b1, 16'd0, ST_OK},
      '{OP_NOTIFY,     64'd0, 16'd0, 1'b0, 16'd244, ST_OK},
      '{OP_NOTIFY,     64'd0, 16'd0, 1'b0, 16'd245, ST_TOO_LONG},
      '{OP_NOTIFY,     64'd0, 16'd0, 1'b0, 16'hFFFF, ST_TOO_LONG},
      '{OP_NOTIFY,     64'd0, 16'd0, 1'b0, 16'd1, NO_PIN},
      '{OP_NOTIFY,     64'd0, 16'd0, 1'b0, 16'd1, NO_PIN},
      '{OP_NOTIFY,     64'd0, 16'd0, 1'b0, 16'd1, NO_PIN},
      '{OP_NOTIFY,     64'd0, 16'd0, 1'b0, 16'd1, ST_NO_CREDIT},
      '{OP_CONN_EVENT, 64'd8499, 16'd0, 1'b0, 16'd0, ST_EARLY},
      '{OP_CONN_EVENT, 64'd8500, 16'd0, 1'b0, 16'd0, NO_PIN},
      '{OP_SET_MTU,    64'd0, 16'd23, 1'b0, 16'd0, ST_OK},
      '{OP_NOTIFY,     64'd0, 16'd0, 1'b0, 16'd20, NO_PIN},
      '{OP_NOTIFY,     64'd0, 16'd0, 1'b0, 16'd21, ST_TOO_LONG},
      '{OP_SET_STALL,  64'd0, 16'd0, 1'b1, 16'd0, ST_OK},
      '{OP_CONN_EVENT, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0, 1'b0, 16'd0, NO_PIN},
      '{OP_DISCONNECT, 64'd0, 16'd0, 1'b0, 16'd0, NO_PIN}
   };

   ble_link_credit_tracker_core u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int payload_room(logic [MTU_W-1:0] mtu);
      if (mtu < DEF_MIN_MTU) begin
         return DEF_SMALL_MTU_VALUE_MAX;
      end
      return ((mtu > DEF_MAX_MTU) ? DEF_MAX_MTU : int'(mtu)) - DEF_VALUE_OVERHEAD;
   endfunction

   // advance the link state by one event and return the report it should give
   function automatic link_report_type apply_link_event(logic [OP_W-1:0] op,
         logic [TIME_W-1:0] now, logic [ARG_W-1:0] mtu_arg, logic flag,
         logic [ARG_W-1:0] len);
      link_report_type   r;
      logic [ARG_W-1:0]  mtu_c;
      logic [TIME_W-1:0] steps;
      r = '0;
      r.status = ST_OK;
      case (op)
         OP_CONNECT: begin
            if (sh_interval == '0 || sh_limit == '0) begin
               r.status = ST_BAD_ARG;
            end else begin
               lk_gen = lk_gen + 1'b1;
               if (lk_gen == '0) begin
                  lk_gen = TOTAL_W'(1);
               end
               mtu_c = mtu_arg;
               if (mtu_c < DEF_MIN_MTU) begin
                  mtu_c = ARG_W'(DEF_MIN_MTU);
               end
               if (mtu_c > DEF_MAX_MTU) begin
                  mtu_c = ARG_W'(DEF_MAX_MTU);
               end
               lk_mtu = mtu_c[MTU_W-1:0];
               lk_credits = sh_limit;
               lk_pending = '0;
               lk_up = 1'b1;
               lk_notify = flag;
               lk_stalled = 1'b0;
               lk_due = now + TIME_W'(sh_interval);
            end
         end
         OP_DISCONNECT: begin
            r.count = lk_pending;
            lk_dropped = lk_dropped + TOTAL_W'(lk_pending);
            lk_credits = '0;
            lk_pending = '0;
            lk_up = 1'b0;
            lk_notify = 1'b0;
            lk_stalled = 1'b0;
            lk_due = '0;
         end
         OP_SET_MTU: begin
            if (mtu_arg < DEF_MIN_MTU || mtu_arg > DEF_MAX_MTU) begin
               r.status = ST_BAD_ARG;
            end else if (!lk_up) begin
               r.status = ST_NOT_CONN;
            end else begin
               lk_mtu = mtu_arg[MTU_W-1:0];
            end
         end
         OP_SET_STALL: begin
            lk_stalled = flag;
         end
         OP_NOTIFY: begin
            if (len == '0) begin
               r.status = ST_BAD_ARG;
            end else if (!lk_up) begin
               r.status = ST_NOT_CONN;
            end else if (!lk_notify) begin
               r.status = ST_NOTIFY_OFF;
            end else if (int'(len) > payload_room(lk_mtu)) begin
               r.status = ST_TOO_LONG;
            end else if (lk_credits == '0 || lk_pending >= sh_limit) begin
               r.status = ST_NO_CREDIT;
            end else begin
               lk_credits = lk_credits - 1'b1;
               lk_pending = lk_pending + 1'b1;
               lk_submitted = lk_submitted + 1'b1;
            end
         end
         OP_CONN_EVENT: begin
            if (!lk_up) begin
               r.status = ST_NOT_CONN;
            end else if (now < lk_due) begin
               r.status = ST_EARLY;
            end else begin
               // a cleared interval freezes the schedule
               if (sh_interval != '0) begin
                  steps = (now - lk_due) / TIME_W'(sh_interval) + 1'b1;
                  lk_due = lk_due + steps * TIME_W'(sh_interval);
               end
               if (!lk_stalled) begin
                  r.count = lk_pending;
                  lk_completed = lk_completed + TOTAL_W'(lk_pending);
                  lk_pending = '0;
                  lk_credits = sh_limit;
               end
            end
         end
         default: begin
            r.status = ST_BAD_ARG;
         end
      endcase
      r.credits = lk_credits;
      r.pending = lk_pending;
      r.link_up = lk_up;
      r.mtu = lk_mtu;
      r.generation = lk_gen;
      r.submitted = lk_submitted;
      r.completed = lk_completed;
      r.dropped = lk_dropped;
      return r;
   endfunction

   function automatic string fmt_report(link_report_type r);
      return $sformatf({"st=%0d cnt=%0d cr=%0d pend=%0d up=%0d mtu=%0d gen=%0d ",
                        "sub=%0d cmp=%0d drop=%0d"},
                       r.status, r.count, r.credits, r.pending, r.link_up, r.mtu,
                       r.generation, r.submitted, r.completed, r.dropped);
   endfunction

   // predict on every accepted request beat, check every accepted response beat
   always @(posedge clock) begin
      link_report_type want, got;
      int              pin;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            want = apply_link_event(req_tuser, req_tdata[REQ_NOW_LO +: TIME_W],
                                    req_tdata[REQ_MTU_LO +: ARG_W], req_tdata[REQ_FLAG_LO],
                                    req_tdata[REQ_LEN_LO +: ARG_W]);
            pin = (pinned_q.size() != 0) ? pinned_q.pop_front() : NO_PIN;
            if (pin != NO_PIN) begin
               want.status = pin[STATUS_W-1:0];
            end
            report_q.push_back(want);
            events_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            got.pad = '0;
            if (report_q.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS) begin
                  $display("%0t: response beat with nothing expected: %s", $realtime,
                           fmt_report(got));
               end
            end else begin
               want = report_q.pop_front();
               reports_checked++;
               if (want.status == ST_OK) begin
                  ok_reports++;
               end
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= MAX_REPORTS) begin
                     $display("%0t: response mismatch", $realtime);
                     $display("   expected %s", fmt_report(want));
                     $display("   actual   %s", fmt_report(got));
                  end
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp_tready = calm || ($urandom_range(99) >= STALL_PCT);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("timeout: no beat moved in %0d cycles", WATCHDOG_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   // entered and left at a falling edge; valid stays up for back-to-back beats
   task automatic send_event(input logic [OP_W-1:0] op, input logic [TIME_W-1:0] now,
                             input logic [ARG_W-1:0] mtu_arg, input logic flag,
                             input logic [ARG_W-1:0] len, input int pin);
      while (!calm && $urandom_range(99) < STALL_PCT) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      pinned_q.push_back(pin);
      req_tuser = op;
      req_tdata = '0;
      req_tdata[REQ_NOW_LO +: TIME_W] = now;
      req_tdata[REQ_MTU_LO +: ARG_W] = mtu_arg;
      req_tdata[REQ_FLAG_LO] = flag;
      req_tdata[REQ_LEN_LO +: ARG_W] = len;
      req_tvalid = 1'b1;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_ADDR_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      req_tvalid = 1'b0;
      while (report_q.size() != 0) begin
         @(negedge clock);
      end
      csr_we = 1'b1;
      csr_addr = idx;
      csr_wdata = val;
      if (idx == CSR_EVENT_INTERVAL) begin
         sh_interval = val;
      end else begin
         sh_limit = val[CNT8_W-1:0];
      end
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // mostly well-formed link traffic shaped by the current link state
   task automatic send_random_event();
      logic [OP_W-1:0]   op;
      logic [TIME_W-1:0] now;
      logic [ARG_W-1:0]  mtu_arg, len;
      logic              flag;
      int                pick, room;
      pick = $urandom_range(99);
      now = {$urandom, $urandom};
      mtu_arg = ARG_W'($urandom);
      flag = 1'($urandom_range(1));
      len = ARG_W'($urandom);
      if (pick < 8) begin
         op = OP_CONNECT;
      end else if (pick < 13) begin
         op = OP_DISCONNECT;
      end else if (pick < 21) begin
         op = OP_SET_MTU;
      end else if (pick < 27) begin
         op = OP_SET_STALL;
      end else if (pick < 72) begin
         op = OP_NOTIFY;
      end else if (pick < 97) begin
         op = OP_CONN_EVENT;
      end else begin
         op = pick[0] ? OP_RESERVED_7 : OP_RESERVED_6;
      end
      if (!lk_up && $urandom_range(99) < 50) begin
         op = OP_CONNECT;
      end
      pick = $urandom_range(99);
      case (op)
         OP_CONNECT: begin
            flag = ($urandom_range(99) < 85);
            if ($urandom_range(2) != 0) begin
               mtu_arg = (pick < 50) ? ARG_W'($urandom_range(DEF_MIN_MTU, DEF_MAX_MTU))
                                     : ARG_W'($urandom_range(0, 30));
            end
            if (pick < 80) begin
               now = lk_due + TIME_W'($urandom_range(0, 5000));
            end else if (pick < 90) begin
               now = 64'hFFFF_FFFF_FFFF_FFFF - TIME_W'($urandom_range(0, 20000));
            end
         end
         OP_SET_MTU: begin
            if (pick < 70) begin
               mtu_arg = ARG_W'($urandom_range(DEF_MIN_MTU, DEF_MAX_MTU));
            end else if (pick < 80) begin
               mtu_arg = ARG_W'(pick[0] ? DEF_MIN_MTU - 1 : DEF_MAX_MTU + 1);
            end
         end
         OP_SET_STALL: begin
            flag = ($urandom_range(99) < 30);
         end
         OP_NOTIFY: begin
            room = payload_room(lk_mtu);
            if (pick < 80) begin
               len = ARG_W'($urandom_range(1, room));
            end else if (pick < 85) begin
               len = '0;
            end else if (pick < 93) begin
               len = ARG_W'(room + 1);
            end
         end
         OP_CONN_EVENT: begin
            if (pick < 10) begin
               now = lk_due - 1'b1;
            end else if (pick < 55) begin
               now = lk_due + TIME_W'($urandom_range(0, 2000));
            end else if (pick < 75) begin
               now = lk_due;
            end else if (pick < 90) begin
               now = lk_due + ({$urandom, $urandom} >> $urandom_range(0, 63));
            end
         end
         default: begin
         end
      endcase
      send_event(op, now, mtu_arg, flag, len, NO_PIN);
   endtask

   initial begin
      int i, ph;
      sh_interval = RST_EVENT_INTERVAL;
      sh_limit = RST_CREDIT_LIMIT;
      lk_up = 1'b0;
      lk_notify = 1'b0;
      lk_stalled = 1'b0;
      lk_mtu = '0;
      lk_credits = '0;
      lk_pending = '0;
      lk_due = '0;
      lk_gen = '0;
      lk_submitted = '0;
      lk_completed = '0;
      lk_dropped = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (i = 0; i < PLAN_ROWS; i++) begin
         send_event(plan[i].op, plan[i].now, plan[i].mtu, plan[i].flag, plan[i].len,
                    plan[i].pin);
      end

      for (ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: begin
            end
            1: begin
               write_csr(CSR_EVENT_INTERVAL, 32'd1);
               write_csr(CSR_CREDIT_LIMIT, 32'd255);
            end
            2: begin
               write_csr(CSR_EVENT_INTERVAL, 32'hFFFF_FFFF);
               write_csr(CSR_CREDIT_LIMIT, 32'd1);
            end
            // connects fail here, a link left up runs on a frozen schedule
            3: begin
               write_csr(CSR_EVENT_INTERVAL, 32'd0);
               write_csr(CSR_CREDIT_LIMIT, 32'd6);
            end
            4: begin
               write_csr(CSR_EVENT_INTERVAL, 32'd7500);
               write_csr(CSR_CREDIT_LIMIT, 32'd0);
            end
            default: begin
               write_csr(CSR_EVENT_INTERVAL, ($urandom_range(3) == 0) ? $urandom
                                                               : $urandom_range(1, 20000));
               write_csr(CSR_CREDIT_LIMIT, $urandom_range(1, 16));
            end
         endcase
         if (ph != 0) begin
            settings_used++;
         end
         calm = (ph == CALM_PHASE);
         for (i = 0; i < PHASE_ITEMS; i++) begin
            send_random_event();
         end
      end

      req_tvalid = 1'b0;
      while (report_q.size() != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("link events: %0d sent (%0d from the directed table) over %0d register settings",
               events_sent, PLAN_ROWS, settings_used);
      $display("responses: %0d compared, %0d with status ok, %0d mismatched",
               reports_checked, ok_reports, mismatches);
      if (mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
